// File: rtl/life_generation_stencil_macros.svh
// assertion helpers, clocked on clock and disabled while reset is high
`ifndef LIFE_GENERATION_STENCIL_MACROS_SVH
`define LIFE_GENERATION_STENCIL_MACROS_SVH

// consequent checked in the same cycle
`define LGS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lgs check failed");

// consequent checked in the next cycle
`define LGS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lgs check failed");

`endif

// File: rtl/lgs_pkg.sv
`default_nettype none
package lgs_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int GRID_RESET     = 1024;

   // configuration port
   localparam int CSR_W = 11;
   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   // window and rule
   localparam int WIN_COLS = 3;
   localparam int WIN_ROWS = 3;
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef struct packed {
      logic shift;
      logic clear;
   } ctl_type;

   typedef struct packed {
      logic next_alive;
      logic frame_last;
   } rsp_type;

endpackage
`default_nettype wire

// File: rtl/lgs_req_if.sv
`default_nettype none
interface lgs_req_if;
   logic valid;
   logic ready;
   logic func;
   logic cell_alive;

   modport source (output valid, output func, output cell_alive, input ready);
   modport sink (input valid, input func, input cell_alive, output ready);
endinterface
`default_nettype wire

// File: rtl/lgs_rsp_if.sv
`default_nettype none
interface lgs_rsp_if;
   logic valid;
   logic ready;
   logic next_alive;
   logic frame_last;

   modport source (output valid, output next_alive, output frame_last, input ready);
   modport sink (input valid, input next_alive, input frame_last, output ready);
endinterface
`default_nettype wire

// File: rtl/lgs_column_cell.sv
`default_nettype none
module lgs_column_cell
   import lgs_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ctl_type             ctl,
   input  wire logic [WIN_ROWS-1:0] col_src,
   output logic      [WIN_ROWS-1:0] col_out
);

   logic [WIN_ROWS-1:0] col_ff;
   logic [WIN_ROWS-1:0] col_in;

   always_comb begin
      col_in = col_ff;
      if (ctl.clear) begin
         col_in = '0;
      end else if (ctl.shift) begin
         col_in = col_src;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

endmodule
`default_nettype wire

// File: rtl/lgs_line_store.sv
`default_nettype none
module lgs_line_store
   import lgs_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_WIDTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [1:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [1:0]    rd_data
);

   // bit 1 holds the upper line, bit 0 the lower line
   logic [1:0] mem [DEPTH];
   logic [1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // same-address write passes straight to the read register
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_ff <= wr_data;
      end else begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule
`default_nettype wire

// File: rtl/lgs_rsp_queue.sv
`default_nettype none
module lgs_rsp_queue
   import lgs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   input  wire logic    pop,
   output logic         full,
   output logic         not_empty,
   output rsp_type      head
);

   rsp_type    q_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = q_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// File: rtl/life_generation_stencil.sv
// One B3/S23 Life generation over a grid_width x grid_height frame streamed in raster
// order, one request per clock while the result queue has room. The line store is read
// one request ahead from a registered two-line memory and the 3x3 window is a chain of
// two column cells fed by the arriving column, so every request is finished in the cycle
// it is taken. The result for a cell comes out grid_width+1 requests after the cell, so
// each frame needs grid_width+1 drain requests after its last cell; drains before then
// are dropped, cells during the flush act as drains. Results pass through a two-entry
// queue, so requests keep flowing while a result waits. Any register write restarts the
// frame. The line store needs no clearing pass after reset: entries not yet written this
// frame only feed neighbors outside the grid.
`default_nettype none
`include "life_generation_stencil_macros.svh"
module life_generation_stencil
   import lgs_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   lgs_req_if.sink               req,
   lgs_rsp_if.source             rsp,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
   localparam int RST_WIDTH  = (GRID_RESET > MAX_WIDTH) ? MAX_WIDTH : GRID_RESET;
   localparam int RST_HEIGHT = (GRID_RESET > MAX_HEIGHT) ? MAX_HEIGHT : GRID_RESET;

   function automatic logic [3:0] count_live(input logic [7:0] bits);
      logic [3:0] sum;
      sum = 4'd0;
      for (int i = 0; i < 8; i++) begin
         sum = sum + {3'd0, bits[i]};
      end
      return sum;
   endfunction

   logic [COL_W-1:0] ci_ff, ci_in;
   logic [ROW_W-1:0] ri_ff, ri_in;
   logic [WID_W-1:0] wid_ff;
   logic [HGT_W-1:0] hgt_ff;
   logic [WID_W-1:0] wid_cfg;
   logic [HGT_W-1:0] hgt_cfg;

   logic [ROW_W-1:0] h_ext, h_plus;
   logic in_grid, step, emit, last_cell, restart, ci_zero, ci_last;
   logic r_top, r_bot, c_left, c_right;
   logic cell_v, up_bit, lo_bit, center;
   logic [1:0] store_rd;
   logic [WIN_ROWS-1:0] col_new;
   logic [WIN_ROWS-1:0] chain [1:WIN_COLS];
   logic [7:0] nb;
   logic [3:0] live_cnt;
   logic q_full, q_valid;
   ctl_type cell_ctl;
   rsp_type rsp_new, rsp_head;

   // position decode
   assign h_ext   = ROW_W'(hgt_ff);
   assign h_plus  = h_ext + ROW_W'(1);
   assign in_grid = (ri_ff < h_ext);
   assign ci_zero = (ci_ff == '0);
   assign ci_last = ((WID_W'(ci_ff) + WID_W'(1)) == wid_ff);

   assign req.ready = !reset && !q_full;
   assign step = req.valid && req.ready && !(in_grid && req.func);
   assign cell_v = in_grid && req.cell_alive;

   assign emit      = (ri_ff >= ROW_W'(2)) || ((ri_ff == ROW_W'(1)) && !ci_zero);
   assign last_cell = ci_zero && (ri_ff == h_plus);
   assign r_top   = (!ci_zero && (ri_ff == ROW_W'(1))) || (ci_zero && (ri_ff == ROW_W'(2)));
   assign r_bot   = (!ci_zero && (ri_ff == h_ext)) || (ci_zero && (ri_ff == h_plus));
   assign c_left  = (ci_ff == COL_W'(1)) || (ci_zero && (wid_ff == WID_W'(1)));
   assign c_right = ci_zero;

   assign restart = csr_we || (step && emit && last_cell);

   // next position; the line store is read at the next position ahead of time
   always_comb begin
      ci_in = ci_ff;
      ri_in = ri_ff;
      if (restart) begin
         ci_in = '0;
         ri_in = '0;
      end else if (step) begin
         if (ci_last) begin
            ci_in = '0;
            ri_in = ri_ff + ROW_W'(1);
         end else begin
            ci_in = ci_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      if (csr_wdata == '0) begin
         wid_cfg = WID_W'(1);
      end else if (32'(csr_wdata) > MAX_WIDTH) begin
         wid_cfg = WID_W'(MAX_WIDTH);
      end else begin
         wid_cfg = WID_W'(csr_wdata);
      end
      if (csr_wdata == '0) begin
         hgt_cfg = HGT_W'(1);
      end else if (32'(csr_wdata) > MAX_HEIGHT) begin
         hgt_cfg = HGT_W'(MAX_HEIGHT);
      end else begin
         hgt_cfg = HGT_W'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ci_ff  <= '0;
         ri_ff  <= '0;
         wid_ff <= WID_W'(RST_WIDTH);
         hgt_ff <= HGT_W'(RST_HEIGHT);
      end else begin
         ci_ff <= ci_in;
         ri_ff <= ri_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_GRID_WIDTH:  wid_ff <= wid_cfg;
               REG_GRID_HEIGHT: hgt_ff <= hgt_cfg;
               default:         wid_ff <= wid_ff;
            endcase
         end
      end
   end

   lgs_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (COL_W)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (step),
      .wr_addr (ci_ff),
      .wr_data ({lo_bit, cell_v}),
      .rd_addr (ci_in),
      .rd_data (store_rd)
   );

   assign up_bit  = store_rd[1];
   assign lo_bit  = store_rd[0];
   assign col_new = {cell_v, lo_bit, up_bit};

   assign cell_ctl.shift = step;
   assign cell_ctl.clear = restart;

   // window: chain[k] is the column held in cell k, chain[WIN_COLS] the arriving column
   assign chain[WIN_COLS] = col_new;
   for (genvar k = 1; k < WIN_COLS; k++) begin : g_cell
      lgs_column_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (cell_ctl),
         .col_src (chain[k+1]),
         .col_out (chain[k])
      );
   end

   // after this request's shift the window columns are chain[1], chain[2], chain[3]
   assign nb[0] = chain[1][0] && !c_left && !r_top;
   assign nb[1] = chain[1][1] && !c_left;
   assign nb[2] = chain[1][2] && !c_left && !r_bot;
   assign nb[3] = chain[2][0] && !r_top;
   assign nb[4] = chain[2][2] && !r_bot;
   assign nb[5] = chain[3][0] && !c_right && !r_top;
   assign nb[6] = chain[3][1] && !c_right;
   assign nb[7] = chain[3][2] && !c_right && !r_bot;
   assign center   = chain[2][1];
   assign live_cnt = count_live(nb);

   assign rsp_new.next_alive = (live_cnt == BIRTH_COUNT) ||
                               (center && (live_cnt == SURVIVE_COUNT));
   assign rsp_new.frame_last = last_cell;

   lgs_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step && emit),
      .push_data (rsp_new),
      .pop       (rsp.valid && rsp.ready),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (rsp_head)
   );

   assign rsp.valid      = q_valid;
   assign rsp.next_alive = rsp_head.next_alive;
   assign rsp.frame_last = rsp_head.frame_last;

   `LGS_ASSERT_NXT(a_rewrap, step && emit && last_cell, (ri_ff == '0) && (ci_ff == '0))
   `LGS_ASSERT_IMP(a_col_range, 1'b1, WID_W'(ci_ff) < wid_ff)
   `LGS_ASSERT_IMP(a_row_range, 1'b1, ri_ff <= h_plus)
   `LGS_ASSERT_NXT(a_drain_hold, req.valid && req.ready && req.func && in_grid && !csr_we, $stable(ri_ff) && $stable(ci_ff))

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
module tb;
   import lgs_pkg::*;

   localparam logic FUNC_CELL  = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   localparam int RANDOM_ITEMS = 520;
   localparam int QUIET_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 500000;

   // row 0: 1 1 0, row 1: 1 1 1, row 2: 0 1 0 (bit i is raster cell i)
   localparam logic [8:0] DIRECTED_PATTERN = 9'b010111011;

   typedef struct packed {
      logic func;
      logic cell_alive;
   } grid_request_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [CSR_W-1:0] csr_wdata;

   lgs_req_if req ();
   lgs_rsp_if rsp ();

   life_generation_stencil dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   grid_request_type pending_requests[$];
   rsp_type          next_gen_q[$];

   // local copy of the stencil state
   logic             store_upper [DEF_MAX_WIDTH];
   logic             store_lower [DEF_MAX_WIDTH];
   logic [8:0]       window_bits;
   logic [10:0]      cur_row;
   logic [9:0]       cur_col;
   logic [20:0]      emitted;
   logic [CSR_W-1:0] width_reg;
   logic [CSR_W-1:0] height_reg;

   int   send_idle_pct = 31;
   int   rsp_idle_pct  = 87;
   int   queued_total  = 0;
   int   fail_count    = 0;
   int   cycle_count   = 0;
   logic req_taken     = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int grid_dim(logic [CSR_W-1:0] value, int max_dim);
      if (value == 0) return 1;
      if (value > max_dim) return max_dim;
      return int'(value);
   endfunction

   function automatic void restart_frame_state();
      window_bits = '0;
      cur_row     = '0;
      cur_col     = '0;
      emitted     = '0;
   endfunction

   // advance the stencil by one request, returns 1 when a result is due
   function automatic bit life_step(logic func, logic alive, output rsp_type res);
      int   w, h, total, ri, ci, r, c, n;
      logic v, up, lo;
      bit   got;
      w     = grid_dim(width_reg, DEF_MAX_WIDTH);
      h     = grid_dim(height_reg, DEF_MAX_HEIGHT);
      total = w * h;
      ri    = int'(cur_row);
      ci    = int'(cur_col);
      v     = 1'b0;
      got   = 1'b0;
      res   = '0;
      if (ri < h) begin
         if (func == FUNC_DRAIN) return 1'b0;
         v = alive;
      end
      if (ci >= w) ci = 0;
      up = store_upper[ci];
      lo = store_lower[ci];
      store_upper[ci] = lo;
      store_lower[ci] = v;
      window_bits = {v, lo, up, window_bits[8:3]};
      if ((ri >= 2 || (ri == 1 && ci >= 1)) && emitted < total) begin
         r = (ci > 0) ? ri - 1 : ri - 2;
         c = (ci > 0) ? ci - 1 : w - 1;
         n = 0;
         // neighbors outside the grid count as dead
         for (int k = 0; k < 3; k++)
            for (int row = 0; row < 3; row++)
               if (!(k == 0 && c == 0) && !(k == 2 && c + 1 >= w) && !(k == 1 && row == 1)
                   && !(row == 0 && r == 0) && !(row == 2 && r + 1 >= h))
                  n += int'(window_bits[3 * k + row]);
         res.next_alive = window_bits[4] ? (n == SURVIVE_COUNT || n == BIRTH_COUNT)
                                         : (n == BIRTH_COUNT);
         res.frame_last = (emitted == total - 1);
         emitted++;
         got = 1'b1;
         if (emitted >= total) begin
            restart_frame_state();
            return got;
         end
      end
      ci++;
      if (ci >= w) begin
         ci = 0;
         ri++;
      end
      cur_col = 10'(ci);
      cur_row = 11'(ri);
      return got;
   endfunction

   always @(negedge clock) begin : drive_requests
      grid_request_type item;
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req_taken) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item = pending_requests.pop_front();
            req.valid      <= 1'b1;
            req.func       <= item.func;
            req.cell_alive <= item.cell_alive;
         end else begin
            req.valid <= 1'b0;
         end
      end
      rsp.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin : watch_results
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req.valid && req.ready;
         if (req.valid && req.ready) begin
            if (life_step(req.func, req.cell_alive, want)) next_gen_q.push_back(want);
         end
         if (rsp.valid && rsp.ready) begin
            if (next_gen_q.size() == 0) begin
               $error("result with no cell pending: next_alive %0b frame_last %0b",
                      rsp.next_alive, rsp.frame_last);
               fail_count++;
            end else begin
               want = next_gen_q.pop_front();
               if (rsp.next_alive !== want.next_alive) begin
                  $error("next_alive: expected %0b, got %0b", want.next_alive, rsp.next_alive);
                  fail_count++;
               end
               if (rsp.frame_last !== want.frame_last) begin
                  $error("frame_last: expected %0b, got %0b", want.frame_last, rsp.frame_last);
                  fail_count++;
               end
            end
         end
      end
   end

   task automatic queue_request(logic func, logic alive);
      grid_request_type item;
      item.func       = func;
      item.cell_alive = alive;
      pending_requests.push_back(item);
      queued_total++;
   endtask

   task automatic wait_quiet();
      while (pending_requests.size() != 0 || req.valid || next_gen_q.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_grid_reg(logic idx, logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == REG_GRID_WIDTH) width_reg = value;
      else height_reg = value;
      restart_frame_state();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // a frame and its flush, or a cut prefix; noisy adds stray drains and flush cells
   task automatic queue_frame(int w, int h, int density, bit noisy, bit cut_short);
      int cells, span, stop;
      cells = w * h;
      span  = cells + w + 1;
      stop  = cut_short ? int'($urandom_range(span - 1, 0)) : span;
      for (int i = 0; i < stop; i++) begin
         if (i < cells) begin
            if (noisy && $urandom_range(9) == 0)
               queue_request(FUNC_DRAIN, 1'($urandom_range(1)));
            queue_request(FUNC_CELL, $urandom_range(99) < density);
         end else if (noisy && $urandom_range(3) == 0) begin
            queue_request(FUNC_CELL, 1'($urandom_range(1)));
         end else begin
            queue_request(FUNC_DRAIN, 1'($urandom_range(1)));
         end
      end
      if (noisy && !cut_short)
         repeat ($urandom_range(3, 1)) queue_request(FUNC_DRAIN, 1'($urandom_range(1)));
   endtask

   function automatic logic [CSR_W-1:0] pick_dim();
      if ($urandom_range(9) == 0) return '0;
      return CSR_W'($urandom_range(16, 1));
   endfunction

   initial begin
      int  start, kind, frames, choice;
      bit  frame_open;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = REG_GRID_WIDTH;
      csr_wdata      = '0;
      req.valid      = 1'b0;
      req.func       = FUNC_CELL;
      req.cell_alive = 1'b0;
      rsp.ready      = 1'b0;
      for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
         store_upper[i] = 1'b0;
         store_lower[i] = 1'b0;
      end
      width_reg  = CSR_W'(GRID_RESET);
      height_reg = CSR_W'(GRID_RESET);
      restart_frame_state();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset grid is too large to finish, so only five top-row cells are fed
      queue_request(FUNC_DRAIN, 1'b1);
      for (int i = 0; i < 5; i++) queue_request(FUNC_CELL, i[0]);
      wait_quiet();

      // 3x3 frame with birth, survival, crowding, stray drain and cell in flush
      write_grid_reg(REG_GRID_WIDTH, 11'd3);
      write_grid_reg(REG_GRID_HEIGHT, 11'd3);
      queue_request(FUNC_DRAIN, 1'b1);
      for (int i = 0; i < 9; i++) begin
         queue_request(FUNC_CELL, DIRECTED_PATTERN[i]);
         if (i == 4) queue_request(FUNC_DRAIN, 1'b0);
      end
      queue_request(FUNC_DRAIN, 1'b0);
      queue_request(FUNC_CELL, 1'b1);
      queue_request(FUNC_DRAIN, 1'b1);
      queue_request(FUNC_DRAIN, 1'b0);
      queue_request(FUNC_DRAIN, 1'b1);
      queue_request(FUNC_DRAIN, 1'b0);
      wait_quiet();

      // zero width acts as one column, oversize height clamps to the maximum
      write_grid_reg(REG_GRID_WIDTH, 11'd0);
      write_grid_reg(REG_GRID_HEIGHT, 11'h7FF);
      queue_frame(1, DEF_MAX_HEIGHT, 50, 1'b0, 1'b0);

      start      = queued_total;
      frame_open = 1'b1;
      while (queued_total - start < RANDOM_ITEMS) begin
         case ((queued_total - start) * 3 / RANDOM_ITEMS)
            0: begin
               send_idle_pct = 31;
               rsp_idle_pct  = 87;
            end
            1: begin
               send_idle_pct = 87;
               rsp_idle_pct  = 31;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         wait_quiet();
         choice = $urandom_range(9);
         if (frame_open || choice < 8) begin
            write_grid_reg(REG_GRID_WIDTH, pick_dim());
            write_grid_reg(REG_GRID_HEIGHT, pick_dim());
         end else if (choice == 8) begin
            // a lone write still restarts the frame
            write_grid_reg($urandom_range(1) ? REG_GRID_HEIGHT : REG_GRID_WIDTH, pick_dim());
         end
         frame_open = 1'b0;
         frames     = $urandom_range(3, 1);
         for (int f = 0; f < frames; f++) begin
            kind = $urandom_range(99);
            queue_frame(grid_dim(width_reg, DEF_MAX_WIDTH), grid_dim(height_reg, DEF_MAX_HEIGHT),
                        $urandom_range(3) * 25 + 10, kind >= 70, kind >= 90);
            if (kind >= 90) begin
               frame_open = 1'b1;
               break;
            end
         end
      end

      wait_quiet();
      if (fail_count == 0 && next_gen_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
